// ===== hw/rtl/pli_pkg.sv =====
// Shared types and constants for the positional list block.
package pli_pkg;

  localparam int LEN_W  = 7;
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic ready_in;
    logic load_req;
    logic exec;
    logic stream_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_stream;
    logic stream_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/pli_req_if.sv =====
// Request channel carrying one operation word.
interface pli_req_if;
  logic                        valid;
  logic                        ready;
  logic [pli_pkg::OP_W-1:0]    operation;
  logic [pli_pkg::POS_W-1:0]   position;
  logic signed [pli_pkg::DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink (input valid, operation, position, value, output ready);
endinterface

// ===== hw/rtl/pli_rsp_if.sv =====
// Response channel carrying one result word.
interface pli_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pli_pkg::STAT_W-1:0]  status;
  logic signed [pli_pkg::DATA_W-1:0] entry;
  logic                        last;

  modport source (output valid, status, entry, last, input ready);
  modport sink (input valid, status, entry, last, output ready);
endinterface

// ===== hw/rtl/pli_ctrl.sv =====
// Controller state machine sequencing request intake, execution and read-out.
module pli_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  pli_pkg::dp_sts_t  sts,
  output pli_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_STREAM = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd              = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready_in = !rst;
        cmd.load_req = req_valid && !rst;
        if (cmd.load_req) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_stream) begin
          state_next = S_STREAM;
        end else if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        if (sts.out_free) begin
          cmd.stream_step = 1'b1;
          if (sts.stream_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pli_dp.sv =====
// Datapath with the row of list cells, the length counter and the output register.
module pli_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pli_pkg::dp_cmd_t                   cmd,
  output pli_pkg::dp_sts_t                   sts,
  input  logic [pli_pkg::OP_W-1:0]           in_operation,
  input  logic [pli_pkg::POS_W-1:0]          in_position,
  input  logic signed [pli_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pli_pkg::STAT_W-1:0]         out_status,
  output logic signed [pli_pkg::DATA_W-1:0]  out_entry,
  output logic                               out_last
);

  localparam int LW = pli_pkg::LEN_W;

  logic [pli_pkg::OP_W-1:0]          op_q;
  logic [pli_pkg::POS_W-1:0]         pos_q;
  logic signed [pli_pkg::DATA_W-1:0] val_q;
  logic [LW-1:0]                     length;
  logic [LW-1:0]                     cnt;
  logic signed [pli_pkg::DATA_W-1:0] cells [CAPACITY];
  logic [pli_pkg::STAT_W-1:0]        res_status;
  logic                              do_ins;
  logic                              do_del;
  logic [LW-1:0]                     pos_l;

  assign pos_l = LW'(pos_q);

  always_comb begin
    res_status = pli_pkg::ST_BADPOS;
    unique case (op_q)
      pli_pkg::OP_INSERT: begin
        if (length == '0 && pos_l != LW'(1)) begin
          res_status = pli_pkg::ST_EMPTY;
        end else if (pos_l == '0 || pos_l > length + LW'(1)) begin
          res_status = pli_pkg::ST_BADPOS;
        end else if (length >= LW'(CAPACITY)) begin
          res_status = pli_pkg::ST_FULL;
        end else begin
          res_status = pli_pkg::ST_OK;
        end
      end
      pli_pkg::OP_DELETE: begin
        if (length == '0) begin
          res_status = pli_pkg::ST_EMPTY;
        end else if (pos_l == '0 || pos_l > length) begin
          res_status = pli_pkg::ST_BADPOS;
        end else begin
          res_status = pli_pkg::ST_OK;
        end
      end
      pli_pkg::OP_READ: begin
        res_status = (length == '0) ? pli_pkg::ST_EMPTY : pli_pkg::ST_OK;
      end
      default: begin
        res_status = pli_pkg::ST_BADPOS;
      end
    endcase
  end

  assign do_ins = cmd.exec && op_q == pli_pkg::OP_INSERT && res_status == pli_pkg::ST_OK;
  assign do_del = cmd.exec && op_q == pli_pkg::OP_DELETE && res_status == pli_pkg::ST_OK;

  assign sts.out_free    = !out_valid || out_ready;
  assign sts.is_stream   = op_q == pli_pkg::OP_READ && length != '0;
  assign sts.stream_last = cnt + LW'(1) == length;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q  <= in_operation;
      pos_q <= in_position;
      val_q <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      cnt    <= '0;
    end else begin
      if (do_ins) begin
        length <= length + LW'(1);
      end else if (do_del) begin
        length <= length - LW'(1);
      end
      if (cmd.load_req) begin
        cnt <= '0;
      end else if (cmd.stream_step) begin
        cnt <= cnt + LW'(1);
      end
    end
  end

  // Each cell looks only at its neighbors, cell zero and the request value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pli_pkg::DATA_W-1:0] lower;
    logic signed [pli_pkg::DATA_W-1:0] upper;
    logic signed [pli_pkg::DATA_W-1:0] cell_next;

    if (i == 0) begin : g_lo_edge
      assign lower = cells[i];
    end else begin : g_lo
      assign lower = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_edge
      assign upper = cells[i];
    end else begin : g_hi
      assign upper = cells[i+1];
    end

    always_comb begin
      cell_next = cells[i];
      priority if (do_ins) begin
        if (i != 0 && LW'(i) >= pos_l) begin
          cell_next = lower;
        end else if (LW'(i + 1) == pos_l) begin
          cell_next = val_q;
        end
      end else if (do_del) begin
        if (LW'(i + 1) >= pos_l && LW'(i + 2) <= length) begin
          cell_next = upper;
        end
      end else if (cmd.stream_step) begin
        if (LW'(i + 2) <= length) begin
          cell_next = upper;
        end else if (LW'(i + 1) == length) begin
          cell_next = cells[0];
        end
      end
    end

    always_ff @(posedge clk) begin
      cells[i] <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.stream_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= res_status;
      out_entry  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.stream_step) begin
      out_status <= pli_pkg::ST_OK;
      out_entry  <= cells[0];
      out_last   <= sts.stream_last;
    end
  end

endmodule

// ===== hw/rtl/positional_list_insert_delete.sv =====
// Insert and delete accept the word, then update every cell of the list in
// parallel and load the output register.
// A read-out accepts the word, then emits one entry per step as the list rotates through cell zero.
// A held output register stalls each of these steps until its word is taken.
// Reset empties the list and clears the controller and the output valid flag.
// Top level of the positional list block.
module positional_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  pli_req_if.sink   req,
  pli_rsp_if.source rsp
);

  pli_pkg::dp_cmd_t cmd;
  pli_pkg::dp_sts_t sts;

  assign req.ready = cmd.ready_in;

  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pli_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (req.operation),
    .in_position  (req.position),
    .in_value     (req.value),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_entry    (rsp.entry),
    .out_last     (rsp.last)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> !cmd.ready_in)
    else $error("request accepted while another is in progress");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_req, cmd.exec, cmd.stream_step}))
    else $error("more than one datapath command in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.stream_step) |-> sts.out_free)
    else $error("result written over a word not yet taken");
`endif

endmodule

// ===== test/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the positional list block: directed table, then random traffic.
module positional_list_insert_delete_tb;

  localparam int CAPACITY = 64;
  localparam logic [pli_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int PLAN_ROWS = 23;

  typedef logic [pli_pkg::POS_W-1:0] pos_t;

  typedef struct packed {
    logic [pli_pkg::STAT_W-1:0] status;
    logic [pli_pkg::DATA_W-1:0] entry;
    logic last;
  } result_word_t;

  typedef struct {
    logic [pli_pkg::OP_W-1:0] op;
    logic [pli_pkg::POS_W-1:0] pos;
    logic [pli_pkg::DATA_W-1:0] val;
    bit known;
    logic [pli_pkg::STAT_W-1:0] status;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    '{pli_pkg::OP_READ,   7'd0,   32'd0,         1'b1, pli_pkg::ST_EMPTY},
    '{pli_pkg::OP_DELETE, 7'd1,   32'd0,         1'b1, pli_pkg::ST_EMPTY},
    '{pli_pkg::OP_INSERT, 7'd2,   32'h1234_5678, 1'b1, pli_pkg::ST_EMPTY},
    '{pli_pkg::OP_INSERT, 7'd0,   32'h0000_0001, 1'b1, pli_pkg::ST_EMPTY},
    '{pli_pkg::OP_INSERT, 7'd127, 32'h0000_0002, 1'b1, pli_pkg::ST_EMPTY},
    '{pli_pkg::OP_INSERT, 7'd1,   32'h7FFF_FFFF, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_INSERT, 7'd0,   32'h0000_0003, 1'b1, pli_pkg::ST_BADPOS},
    '{pli_pkg::OP_INSERT, 7'd3,   32'h0000_0004, 1'b1, pli_pkg::ST_BADPOS},
    '{pli_pkg::OP_INSERT, 7'd2,   32'h8000_0000, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_INSERT, 7'd2,   32'h0000_0000, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_READ,   7'd0,   32'd0,         1'b0, pli_pkg::ST_OK},
    '{pli_pkg::OP_DELETE, 7'd0,   32'd0,         1'b1, pli_pkg::ST_BADPOS},
    '{pli_pkg::OP_DELETE, 7'd5,   32'd0,         1'b1, pli_pkg::ST_BADPOS},
    '{pli_pkg::OP_DELETE, 7'd127, 32'd0,         1'b1, pli_pkg::ST_BADPOS},
    '{OP_UNUSED,          7'd1,   32'hDEAD_BEEF, 1'b1, pli_pkg::ST_BADPOS},
    '{pli_pkg::OP_DELETE, 7'd4,   32'd0,         1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_DELETE, 7'd1,   32'd0,         1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_READ,   7'd0,   32'd0,         1'b0, pli_pkg::ST_OK},
    '{pli_pkg::OP_INSERT, 7'd3,   32'h5555_5555, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_INSERT, 7'd4,   32'hAAAA_AAAA, 1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_DELETE, 7'd2,   32'd0,         1'b1, pli_pkg::ST_OK},
    '{pli_pkg::OP_READ,   7'd0,   32'd0,         1'b0, pli_pkg::ST_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pli_req_if req ();
  pli_rsp_if rsp ();

  positional_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  logic signed [pli_pkg::DATA_W-1:0] list_cells[$];
  result_word_t pending_results[$];

  int cycles = 0;
  int mismatches = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int deepest_list = 0;
  int hold_left = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles, %0d results still expected", cycles,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic list_apply(input logic [pli_pkg::OP_W-1:0] op,
                            input logic [pli_pkg::POS_W-1:0] pos,
                            input logic [pli_pkg::DATA_W-1:0] val);
    int len;
    logic [pli_pkg::STAT_W-1:0] st;
    len = list_cells.size();
    st = pli_pkg::ST_OK;
    if (op == pli_pkg::OP_INSERT) begin
      if (len == 0 && pos != 1) begin
        st = pli_pkg::ST_EMPTY;
      end else if (pos < 1 || pos > len + 1) begin
        st = pli_pkg::ST_BADPOS;
      end else if (len >= CAPACITY) begin
        st = pli_pkg::ST_FULL;
        full_refusals++;
      end else begin
        list_cells.insert(pos - 1, val);
      end
    end else if (op == pli_pkg::OP_DELETE) begin
      if (len == 0) begin
        st = pli_pkg::ST_EMPTY;
      end else if (pos < 1 || pos > len) begin
        st = pli_pkg::ST_BADPOS;
      end else begin
        list_cells.delete(pos - 1);
      end
    end else if (op == pli_pkg::OP_READ) begin
      if (len == 0) begin
        st = pli_pkg::ST_EMPTY;
      end
    end else begin
      st = pli_pkg::ST_BADPOS;
    end
    if (op == pli_pkg::OP_READ && len != 0) begin
      for (int i = 0; i < len; i++) begin
        pending_results.push_back('{pli_pkg::ST_OK, list_cells[i], (i == len - 1)});
      end
    end else begin
      pending_results.push_back('{st, '0, 1'b1});
    end
    if (list_cells.size() > deepest_list) begin
      deepest_list = list_cells.size();
    end
  endtask

  task automatic send_word(input logic [pli_pkg::OP_W-1:0] op,
                           input logic [pli_pkg::POS_W-1:0] pos,
                           input logic [pli_pkg::DATA_W-1:0] val);
    while (!steady && $urandom_range(99) < 18) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.position <= pos;
    req.value <= val;
    do @(posedge clk); while (!req.ready);
    words_accepted++;
    list_apply(op, pos, val);
  endtask

  task automatic send_random(input bit filling);
    int roll;
    int len;
    logic [pli_pkg::OP_W-1:0] op;
    logic [pli_pkg::POS_W-1:0] pos;
    logic [pli_pkg::DATA_W-1:0] val;
    roll = $urandom_range(99);
    len = list_cells.size();
    val = $urandom();
    pos = pos_t'($urandom_range(127));
    if (roll < (filling ? 80 : 6)) begin
      op = pli_pkg::OP_INSERT;
      pos = (len == 0) ? pos_t'(1) : pos_t'($urandom_range(len + 1, 1));
    end else if (roll < (filling ? 86 : 82)) begin
      op = pli_pkg::OP_DELETE;
      pos = (len == 0) ? pos_t'(1) : pos_t'($urandom_range(len, 1));
    end else if (roll < 92) begin
      op = pli_pkg::OP_READ;
    end else if (roll < 97) begin
      op = $urandom_range(1) ? pli_pkg::OP_INSERT : pli_pkg::OP_DELETE;
    end else begin
      op = OP_UNUSED;
    end
    send_word(op, pos, val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: unexpected word status=%0d entry=%h last=%b", rsp.status, rsp.entry,
                   rsp.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status || rsp.entry !== want.entry
            || rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: word %0d expected status=%0d entry=%h last=%b, got %0d %h %b",
                     results_checked, want.status, want.entry, want.last, rsp.status,
                     rsp.entry, rsp.last);
          end
        end
      end
    end
  end

  initial begin
    int count;
    req.valid = 1'b0;
    req.operation = pli_pkg::OP_INSERT;
    req.position = '0;
    req.value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_word(plan[i].op, plan[i].pos, plan[i].val);
      if (plan[i].known) begin
        void'(pending_results.pop_back());
        pending_results.push_back('{plan[i].status, '0, 1'b1});
      end
    end

    count = 0;
    while (count < 90 || full_refusals < 3) begin
      if (count == 30) begin
        hold_request = 1'b1;
      end
      send_random(1'b1);
      count++;
    end

    count = 0;
    while (count < 70 || list_cells.size() != 0) begin
      steady = (count >= 20 && count < 60);
      send_random(1'b0);
      count++;
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("tb: %0d expected words never arrived", pending_results.size());
      mismatches++;
    end
    $display("tb: %0d requests accepted, %0d result words checked, %0d mismatches",
             words_accepted, results_checked, mismatches);
    $display("tb: list reached %0d of %0d entries, %0d inserts refused as full",
             deepest_list, CAPACITY, full_refusals);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pli_pkg.sv
hw/rtl/pli_req_if.sv
hw/rtl/pli_rsp_if.sv
hw/rtl/pli_ctrl.sv
hw/rtl/pli_dp.sv
hw/rtl/positional_list_insert_delete.sv
test/positional_list_insert_delete_tb.sv
